/* hw/rtl/bmsb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmsb_pkg: shared types and constants for the bounded multi-stack bank
// Sizes of the stack row, item layouts, operation and status codes.
// ----------------------------------------------------------------------------
package bmsb_pkg;

	localparam int NUM_STACKS  = 16;
	localparam int STACK_DEPTH = 16;
	localparam int VALUE_WIDTH = 32;

	localparam int SIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int DEPTH_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = SIDX_W + DEPTH_W;
	localparam int CAP_W = 5;
	localparam int IDX_W = 4;
	localparam int OP_W = 2;
	localparam int ST_W = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
	localparam logic [OP_W-1:0] OP_POP    = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_AT = 2'd2;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]               operation;
		logic signed [VALUE_WIDTH-1:0] push_value;
		logic [IDX_W-1:0]              stack_index;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] pop_value;
		logic [ST_W-1:0]               status;
	} result_t;

	// request from the control path to the entry memory
	typedef struct packed {
		logic                   we;
		logic [ADDR_W-1:0]      waddr;
		logic [VALUE_WIDTH-1:0] wdata;
		logic                   re;
		logic [ADDR_W-1:0]      raddr;
	} mem_req_t;

endpackage
`default_nettype wire

/* hw/rtl/bounded_multi_stack_bank.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_multi_stack_bank: row of capacity-bounded LIFO stacks
// The result of an item is strobed by done in the cycle after start.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Fill counts sit in flops, stack choice is a priority encode on them, and
// the entry store gives one write and one registered read per cycle.
// Reset: counts cleared, capacity back to 16; stored entries are not cleared.
// ----------------------------------------------------------------------------
module bounded_multi_stack_bank (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire bmsb_pkg::cmd_t               cmd,
	output logic                              done,
	output bmsb_pkg::result_t                 result,
	input  wire logic                         cfg_we,
	input  wire logic [bmsb_pkg::CAP_W-1:0]   cfg_wdata
);

	logic                             accept;
	bmsb_pkg::mem_req_t               req;
	logic [bmsb_pkg::VALUE_WIDTH-1:0] rdata;
	logic                             take;
	logic [bmsb_pkg::ST_W-1:0]        status;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	bmsb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.done      (done),
		.take      (take),
		.status    (status)
	);

	bmsb_mem u_mem (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	// value only on a successful pop
	assign result.pop_value = take ? rdata : '0;
	assign result.status    = status;

endmodule
`default_nettype wire

/* hw/rtl/bmsb_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmsb_mem: entry store
// One write port and one registered read port over all stack slots.
// ----------------------------------------------------------------------------
module bmsb_mem (
	input  wire logic                             clk,
	input  wire bmsb_pkg::mem_req_t               req,
	output logic [bmsb_pkg::VALUE_WIDTH-1:0]      rdata
);

	localparam int WORDS = bmsb_pkg::NUM_STACKS * (2 ** bmsb_pkg::DEPTH_W);

	logic [bmsb_pkg::VALUE_WIDTH-1:0] mem_q [WORDS];
	logic [bmsb_pkg::VALUE_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* hw/rtl/bmsb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmsb_ctrl: fill counts, stack selection and result status
// Picks the leftmost non-full stack for a push and the rightmost non-empty
// stack for a pop or the named stack for a pop-at, updates the counts and issues the memory access.
// ----------------------------------------------------------------------------
module bmsb_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire bmsb_pkg::cmd_t               cmd,
	input  wire logic                         cfg_we,
	input  wire logic [bmsb_pkg::CAP_W-1:0]   cfg_wdata,
	output bmsb_pkg::mem_req_t                req,
	output logic                              done,
	output logic                              take,
	output logic [bmsb_pkg::ST_W-1:0]         status
);

	localparam int NS = bmsb_pkg::NUM_STACKS;
	localparam int CW = bmsb_pkg::CNT_W;
	localparam int SW = bmsb_pkg::SIDX_W;
	localparam int DW = bmsb_pkg::DEPTH_W;

	logic [bmsb_pkg::CAP_W-1:0] cap_q;
	logic [CW-1:0]              counts_q [NS];
	logic [CW-1:0]              eff_cap;
	logic [NS-1:0]              not_full;
	logic [NS-1:0]              non_empty;
	logic                       push_hit;
	logic [SW-1:0]              push_sel;
	logic                       pop_hit;
	logic [SW-1:0]              pop_sel;

	logic                       do_push;
	logic                       do_pop;
	logic [SW-1:0]              pop_stack;
	logic [bmsb_pkg::ST_W-1:0]  status_d;

	logic                       done_q;
	logic                       take_q;
	logic [bmsb_pkg::ST_W-1:0]  status_q;

	// capacity above the built depth acts as the depth
	always_comb begin
		if (32'(cap_q) > bmsb_pkg::STACK_DEPTH) begin
			eff_cap = CW'(bmsb_pkg::STACK_DEPTH);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	always_comb begin
		for (int s = 0; s < NS; s++) begin
			not_full[s]  = counts_q[s] < eff_cap;
			non_empty[s] = counts_q[s] != '0;
		end
	end

	// leftmost non-full: scan downward, last hit wins
	always_comb begin
		push_hit = 1'b0;
		push_sel = '0;
		for (int s = NS - 1; s >= 0; s--) begin
			if (not_full[s]) begin
				push_hit = 1'b1;
				push_sel = SW'(s);
			end
		end
	end

	// rightmost non-empty: scan upward, last hit wins
	always_comb begin
		pop_hit = 1'b0;
		pop_sel = '0;
		for (int s = 0; s < NS; s++) begin
			if (non_empty[s]) begin
				pop_hit = 1'b1;
				pop_sel = SW'(s);
			end
		end
	end

	always_comb begin
		do_push   = 1'b0;
		do_pop    = 1'b0;
		pop_stack = pop_sel;
		status_d  = bmsb_pkg::ST_EMPTY;
		case (cmd.operation)
			bmsb_pkg::OP_PUSH: begin
				do_push  = push_hit;
				status_d = push_hit ? bmsb_pkg::ST_OK : bmsb_pkg::ST_FULL;
			end
			bmsb_pkg::OP_POP: begin
				do_pop   = pop_hit;
				status_d = pop_hit ? bmsb_pkg::ST_OK : bmsb_pkg::ST_EMPTY;
			end
			bmsb_pkg::OP_POP_AT: begin
				pop_stack = SW'(cmd.stack_index);
				if (32'(cmd.stack_index) < NS) begin
					do_pop = non_empty[SW'(cmd.stack_index)];
				end
				status_d = do_pop ? bmsb_pkg::ST_OK : bmsb_pkg::ST_EMPTY;
			end
			default: begin
				status_d = bmsb_pkg::ST_EMPTY;
			end
		endcase
	end

	always_comb begin
		logic [CW-1:0] top;
		logic [CW-1:0] push_cnt;
		top      = counts_q[pop_stack] - CW'(1);
		push_cnt = counts_q[push_sel];
		req.we    = accept && do_push;
		req.waddr = {push_sel, push_cnt[DW-1:0]};
		req.wdata = cmd.push_value;
		req.re    = accept && do_pop;
		req.raddr = {pop_stack, top[DW-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bmsb_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NS; s++) begin
				counts_q[s] <= '0;
			end
		end else if (accept) begin
			if (do_push) begin
				counts_q[push_sel] <= counts_q[push_sel] + CW'(1);
			end else if (do_pop) begin
				counts_q[pop_stack] <= counts_q[pop_stack] - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			take_q   <= 1'b0;
			status_q <= bmsb_pkg::ST_OK;
		end else begin
			done_q <= accept;
			if (accept) begin
				take_q   <= do_pop;
				status_q <= status_d;
			end
		end
	end

	assign done   = done_q;
	assign take   = take_q;
	assign status = status_q;

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bounded_multi_stack_bank
// Sends push, pop and pop-at commands, including the unused opcode, under
// several stack capacities. A behavioral copy of the stack row predicts each
// result. Every strobed result is checked in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 200000;

	// opcode with no operation behind it
	localparam logic [bmsb_pkg::OP_W-1:0] OP_SPARE = 2'd3;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	bmsb_pkg::cmd_t                cmd;
	logic                          done;
	bmsb_pkg::result_t             result;
	logic                          cfg_we;
	logic [bmsb_pkg::CAP_W-1:0]    cfg_wdata;

	// predictor state
	logic [bmsb_pkg::CAP_W-1:0]       capacity_model;
	int unsigned                      fill_model [bmsb_pkg::NUM_STACKS];
	logic [bmsb_pkg::VALUE_WIDTH-1:0] plate_model [bmsb_pkg::NUM_STACKS][bmsb_pkg::STACK_DEPTH];

	bmsb_pkg::result_t pending_results [$];
	int                mismatch_count = 0;
	int                cycle_count = 0;
	int                send_idle_pct = 0;

	bounded_multi_stack_bank u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Applies one command to the predictor state and returns its result.
	function automatic bmsb_pkg::result_t stack_row_apply(input bmsb_pkg::cmd_t c);
		bmsb_pkg::result_t r;
		int unsigned       cap;
		int                s;
		bit                taken;
		r.pop_value = '0;
		r.status = bmsb_pkg::ST_EMPTY;
		taken = 1'b0;
		cap = (capacity_model > bmsb_pkg::STACK_DEPTH) ? bmsb_pkg::STACK_DEPTH : capacity_model;
		case (c.operation)
			bmsb_pkg::OP_PUSH: begin
				r.status = bmsb_pkg::ST_FULL;
				for (s = 0; s < bmsb_pkg::NUM_STACKS; s++) begin
					if (!taken && fill_model[s] < cap) begin
						plate_model[s][fill_model[s]] = c.push_value;
						fill_model[s]++;
						r.status = bmsb_pkg::ST_OK;
						taken = 1'b1;
					end
				end
			end
			bmsb_pkg::OP_POP: begin
				for (s = bmsb_pkg::NUM_STACKS - 1; s >= 0; s--) begin
					if (!taken && fill_model[s] != 0) begin
						fill_model[s]--;
						r.pop_value = plate_model[s][fill_model[s]];
						r.status = bmsb_pkg::ST_OK;
						taken = 1'b1;
					end
				end
			end
			bmsb_pkg::OP_POP_AT: begin
				s = c.stack_index;
				if (s < bmsb_pkg::NUM_STACKS && fill_model[s] != 0) begin
					fill_model[s]--;
					r.pop_value = plate_model[s][fill_model[s]];
					r.status = bmsb_pkg::ST_OK;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// results come in the cycle after the item and cannot be held off
	always @(posedge clk) begin
		bmsb_pkg::result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: pop_value %0d status %0d",
					result.pop_value, result.status);
				mismatch_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result.pop_value !== exp_r.pop_value) begin
					$error("pop_value: expected %0d, got %0d",
						exp_r.pop_value, result.pop_value);
					mismatch_count++;
				end
				if (result.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, result.status);
					mismatch_count++;
				end
			end
		end
	end

	function automatic bmsb_pkg::cmd_t make_cmd(input logic [bmsb_pkg::OP_W-1:0] op,
		input logic [bmsb_pkg::VALUE_WIDTH-1:0] v, input logic [bmsb_pkg::IDX_W-1:0] idx);
		bmsb_pkg::cmd_t c;
		c.operation = op;
		c.push_value = v;
		c.stack_index = idx;
		return c;
	endfunction

	function automatic bmsb_pkg::cmd_t noise_cmd();
		return make_cmd(bmsb_pkg::OP_W'($urandom_range(3)), $urandom,
			bmsb_pkg::IDX_W'($urandom_range(15)));
	endfunction

	task automatic send_cmd(input bmsb_pkg::cmd_t c);
		bmsb_pkg::result_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			start = 1'b0;
			cmd = noise_cmd();
			@(negedge clk);
		end
		start = 1'b1;
		cmd = c;
		do @(posedge clk); while (busy);
		predicted = stack_row_apply(c);
		pending_results = {pending_results, predicted};
	endtask

	// stop sending and let every outstanding result arrive
	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [bmsb_pkg::CAP_W-1:0] v);
		drain_results();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(posedge clk);
		capacity_model = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_empty_bank();
		send_cmd(make_cmd(bmsb_pkg::OP_POP, $urandom, 4'd0));
		send_cmd(make_cmd(bmsb_pkg::OP_POP_AT, $urandom, 4'd15));
		send_cmd(make_cmd(OP_SPARE, $urandom, 4'd0));
	endtask

	task automatic test_push_extremes();
		send_cmd(make_cmd(bmsb_pkg::OP_PUSH, 32'h7FFF_FFFF, 4'd15));
		send_cmd(make_cmd(bmsb_pkg::OP_PUSH, 32'h8000_0000, 4'd0));
		send_cmd(make_cmd(bmsb_pkg::OP_PUSH, 32'h0000_0000, 4'd5));
		send_cmd(make_cmd(bmsb_pkg::OP_PUSH, 32'hFFFF_FFFF, 4'd10));
	endtask

	// capacity zero refuses pushes, pops still drain
	task automatic test_zero_capacity();
		write_capacity(5'd0);
		send_cmd(make_cmd(bmsb_pkg::OP_PUSH, $urandom, 4'd0));
		send_cmd(make_cmd(bmsb_pkg::OP_POP, $urandom, 4'd0));
	endtask

	// stack 0 holds more than the new capacity: it counts as full but still pops
	task automatic test_lowered_capacity();
		int i;
		write_capacity(5'd1);
		for (i = 0; i < bmsb_pkg::NUM_STACKS - 1; i++)
			send_cmd(make_cmd(bmsb_pkg::OP_PUSH, $urandom, 4'd0));
		send_cmd(make_cmd(bmsb_pkg::OP_PUSH, $urandom, 4'd0));
		send_cmd(make_cmd(bmsb_pkg::OP_POP_AT, $urandom, 4'd7));
		// refill lands on the stack just emptied
		send_cmd(make_cmd(bmsb_pkg::OP_PUSH, $urandom, 4'd0));
		send_cmd(make_cmd(bmsb_pkg::OP_POP_AT, $urandom, 4'd0));
	endtask

	task automatic test_capacity_above_depth();
		write_capacity(5'd31);
		send_cmd(make_cmd(bmsb_pkg::OP_PUSH, $urandom, 4'd0));
	endtask

	task automatic test_random_traffic(input int count, input int push_pct);
		int             i;
		int             pick;
		bmsb_pkg::cmd_t c;
		for (i = 0; i < count; i++) begin
			c = noise_cmd();
			pick = $urandom_range(99);
			if (pick < push_pct)
				c.operation = bmsb_pkg::OP_PUSH;
			else begin
				pick = $urandom_range(99);
				c.operation = (pick < 45) ? bmsb_pkg::OP_POP :
					(pick < 90) ? bmsb_pkg::OP_POP_AT : OP_SPARE;
			end
			if ($urandom_range(59) == 0)
				drain_results();
			send_cmd(c);
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		capacity_model = bmsb_pkg::CAP_RESET;
		for (i = 0; i < bmsb_pkg::NUM_STACKS; i++)
			fill_model[i] = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 37;
		test_empty_bank();
		test_push_extremes();
		test_zero_capacity();
		test_lowered_capacity();
		test_capacity_above_depth();

		write_capacity(5'd3);
		test_random_traffic(200, 60);

		send_idle_pct = 87;
		write_capacity(5'd5);
		test_random_traffic(200, 65);

		send_idle_pct = 0;
		write_capacity(5'd2);
		test_random_traffic(100, 55);
		write_capacity(5'd16);
		test_random_traffic(100, 40);

		drain_results();
		repeat (5) @(negedge clk);
		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/bmsb_pkg.sv
hw/rtl/bmsb_mem.sv
hw/rtl/bmsb_ctrl.sv
hw/rtl/bounded_multi_stack_bank.sv
tb/testbench.sv
